/* sv/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, widths and constants for the line follower steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int CH_N       = 5;
  localparam int CH_IDX_W   = $clog2(CH_N);
  localparam int SAMPLE_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int GAIN_W     = 8;
  localparam int DUTY_W     = 7;
  localparam int PWM_W      = 8;
  localparam int LAP_W      = 8;

  // normalized channel value, centroid and controller widths
  localparam int NORM_W = 21;
  localparam int CNUM_W = 34;
  localparam int CDEN_W = 28;
  localparam int POS_W  = 32;
  localparam int DER_W  = 33;
  localparam int PROD_W = 42;
  localparam int ACC_W  = 44;

  // divider magnitude widths
  localparam int NUM_W = 32;
  localparam int DEN_W = 26;

  localparam logic OP_CAL = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PREF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd5;

  localparam logic [DUTY_W-1:0] BASE_SPEED_RST = 7'd50;
  localparam logic [GAIN_W-1:0] GAIN_P_RST     = 8'd12;
  localparam logic [GAIN_W-1:0] GAIN_D_RST     = 8'd2;
  localparam logic [GAIN_W-1:0] GAIN_I_RST     = 8'd0;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;

  localparam logic signed [NORM_W-1:0] NORM_FULL = 21'sd1000;
  localparam logic signed [NORM_W-1:0] THR_DARK  = 21'sd150;
  localparam logic signed [NORM_W-1:0] THR_WHITE = 21'sd900;
  localparam logic signed [CNUM_W-1:0] CW_MID    = 34'sd1000;
  localparam logic signed [CNUM_W-1:0] CW_RIGHT  = 34'sd2000;
  localparam logic signed [CDEN_W-1:0] CDEN_SCALE = 28'sd20;
  localparam logic signed [POS_W-1:0]  POS_CENTER = 32'sd50;
  localparam logic [DUTY_W-1:0]        DUTY_MAX   = 7'd100;

  typedef logic [CH_N-1:0][SAMPLE_W-1:0] samples_t;

  typedef struct packed {
    logic              enable;
    logic              turn_pref;
    logic [DUTY_W-1:0] base_speed;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] gain_i;
  } cfg_t;

  typedef struct packed {
    logic                    motors_on;
    logic [PWM_W-1:0]        duty_a;
    logic [PWM_W-1:0]        duty_b;
    logic signed [POS_W-1:0] line_position;
    logic [LAP_W-1:0]        lap_total;
    logic                    lap_event;
    logic                    divide_fault;
  } res_t;

  // floor(d*255/100) for d in 0..100, as d*167127 >> 16
  function automatic logic [PWM_W-1:0] duty_to_pwm(input logic [DUTY_W-1:0] d);
    logic [24:0] p;
    p = 25'(d) * 25'd167127;
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

/* sv/lfpd_cfg.sv */
// ----------------------------------------------------------------------------
// lfpd_cfg
// Configuration register file, written through the config word channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_cfg
  import lfpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable     <= 1'b0;
      cfg.turn_pref  <= 1'b0;
      cfg.base_speed <= BASE_SPEED_RST;
      cfg.gain_p     <= GAIN_P_RST;
      cfg.gain_d     <= GAIN_D_RST;
      cfg.gain_i     <= GAIN_I_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:     cfg.enable     <= wr_data[0];
        REG_TURN_PREF:  cfg.turn_pref  <= wr_data[0];
        REG_BASE_SPEED: cfg.base_speed <= wr_data[DUTY_W-1:0];
        REG_GAIN_P:     cfg.gain_p     <= wr_data;
        REG_GAIN_D:     cfg.gain_d     <= wr_data;
        REG_GAIN_I:     cfg.gain_i     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/lfpd_div.sv */
// ----------------------------------------------------------------------------
// lfpd_div
// Shared restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_div
  import lfpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] qr;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem, qr[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    ge     = ~diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= num;
      rem <= '0;
      dvs <= den;
    end else if (active) begin
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      qr  <= {qr[NUM_W-2:0], ge};
    end
  end

  assign quo = qr;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !active)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !active)
    else $error("divider done while still iterating");

endmodule

`default_nettype wire

/* sv/lfpd_seq.sv */
// ----------------------------------------------------------------------------
// lfpd_seq
// Sequencer: calibration, normalization, lap and fork logic, centroid, PID.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_seq
  import lfpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     operation,
  input  samples_t samples,
  input  cfg_t     cfg,
  input  logic     out_free,
  output logic     idle,
  output logic     res_load,
  output res_t     res
);

  localparam int SUM_W = ACC_W + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_NORM  = 13'b0000000000010,
    S_NWAIT = 13'b0000000000100,
    S_CHECK = 13'b0000000001000,
    S_CENT  = 13'b0000000010000,
    S_CWAIT = 13'b0000000100000,
    S_ERR   = 13'b0000001000000,
    S_MULP  = 13'b0000010000000,
    S_MULD  = 13'b0000100000000,
    S_MULI  = 13'b0001000000000,
    S_SUM   = 13'b0010000000000,
    S_DUTY  = 13'b0100000000000,
    S_WR    = 13'b1000000000000
  } state_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] s);
    logic [DUTY_W-1:0] r;
    if (s[SUM_W-1]) r = '0;
    else if (s[SUM_W-2:0] > (SUM_W-1)'(DUTY_MAX)) r = DUTY_MAX;
    else r = s[DUTY_W-1:0];
    return r;
  endfunction

  state_t                   state;
  logic [CH_IDX_W-1:0]      k;
  samples_t                 samp;
  samples_t                 chan_min;
  samples_t                 chan_max;
  logic signed [NORM_W-1:0] n [CH_N];
  logic                     fault;
  logic                     lap_hit;
  logic                     drive;
  logic                     q_neg;
  logic                     armed;
  logic [LAP_W-1:0]         lap_count;
  logic signed [POS_W-1:0]  pos;
  logic signed [POS_W-1:0]  err;
  logic signed [DER_W-1:0]  der;
  logic signed [POS_W-1:0]  integ;
  logic signed [POS_W-1:0]  prev_error;
  logic signed [POS_W-1:0]  error_integral;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [DUTY_W-1:0]        da;
  logic [DUTY_W-1:0]        db;

  logic signed [SAMPLE_W:0] nm_diff;
  logic signed [SAMPLE_W:0] nm_span;
  logic signed [NORM_W-1:0] nm_num;
  logic [NORM_W-1:0]        nm_num_mag;
  logic [SAMPLE_W:0]        nm_span_mag;
  logic signed [CNUM_W-1:0] c_num;
  logic signed [CDEN_W-1:0] c_den;
  logic [CNUM_W-1:0]        c_num_mag;
  logic [CDEN_W-1:0]        c_den_mag;
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic signed [NUM_W:0]    q_signed;
  logic signed [POS_W-1:0]  err_v;
  logic signed [DER_W-1:0]  der_v;
  logic signed [DER_W-1:0]  integ_sum;
  logic signed [POS_W-1:0]  integ_sat;
  logic signed [DER_W-1:0]  mul_a;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  sum_a;
  logic signed [SUM_W-1:0]  sum_b;
  logic                     all_white;
  logic                     stop;
  logic                     lap_arm;
  logic                     lap_disarm;
  logic                     fork_hit;
  logic                     last_ch;

  // normalization operands for channel k
  always_comb begin
    nm_diff     = $signed({1'b0, samp[k]}) - $signed({1'b0, chan_min[k]});
    nm_span     = $signed({1'b0, chan_max[k]}) - $signed({1'b0, chan_min[k]});
    nm_num      = NORM_W'(nm_diff) * NORM_FULL;
    nm_num_mag  = nm_num[NORM_W-1] ? NORM_W'(-nm_num) : NORM_W'(nm_num);
    nm_span_mag = nm_span[SAMPLE_W] ? (SAMPLE_W+1)'(-nm_span) : (SAMPLE_W+1)'(nm_span);
  end

  // centroid operands
  always_comb begin
    c_num     = CNUM_W'(n[2]) * CW_MID + CNUM_W'(n[3]) * CW_RIGHT;
    c_den     = (CDEN_W'(n[1]) + CDEN_W'(n[2]) + CDEN_W'(n[3])) * CDEN_SCALE;
    c_num_mag = c_num[CNUM_W-1] ? CNUM_W'(-c_num) : CNUM_W'(c_num);
    c_den_mag = c_den[CDEN_W-1] ? CDEN_W'(-c_den) : CDEN_W'(c_den);
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(nm_num_mag);
    div_den   = DEN_W'(nm_span_mag);
    if (state == S_NORM) begin
      div_start = (nm_span != '0);
    end else if (state == S_CENT) begin
      div_start = (c_den != '0);
      div_num   = c_num_mag[NUM_W-1:0];
      div_den   = c_den_mag[DEN_W-1:0];
    end
  end

  lfpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_signed = q_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign last_ch  = (k == CH_IDX_W'(CH_N - 1));

  // frame classification
  always_comb begin
    all_white  = (n[0] > THR_WHITE) && (n[1] > THR_WHITE) && (n[2] > THR_WHITE) &&
                 (n[3] > THR_WHITE) && (n[4] > THR_WHITE);
    stop       = !cfg.enable || all_white;
    lap_arm    = (n[0] < THR_DARK) && (n[4] < THR_DARK) && (n[2] < THR_DARK) && !armed;
    lap_disarm = (n[0] > THR_WHITE) && (n[4] > THR_WHITE) && armed;
    fork_hit   = (n[1] < THR_DARK) && (n[3] < THR_DARK);
  end

  // error terms, saturating integral
  always_comb begin
    err_v     = pos - POS_CENTER;
    der_v     = DER_W'(err_v) - DER_W'(prev_error);
    integ_sum = DER_W'(error_integral) + DER_W'(err_v);
    if (integ_sum[DER_W-1] != integ_sum[POS_W-1]) begin
      integ_sat = integ_sum[DER_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[POS_W-1:0];
    end
  end

  // shared gain multiplier
  always_comb begin
    unique case (state)
      S_MULP: begin
        mul_a = DER_W'(err);
        mul_b = $signed({1'b0, cfg.gain_p});
      end
      S_MULD: begin
        mul_a = der;
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      default: begin
        mul_a = DER_W'(integ);
        mul_b = $signed({1'b0, cfg.gain_i});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    sum_a = SUM_W'($signed({1'b0, cfg.base_speed})) - SUM_W'(acc);
    sum_b = SUM_W'($signed({1'b0, cfg.base_speed})) + SUM_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      chan_min       <= {CH_N{SAMPLE_MAX}};
      chan_max       <= '0;
      armed          <= 1'b0;
      lap_count      <= '0;
      prev_error     <= '0;
      error_integral <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            samp    <= samples;
            fault   <= 1'b0;
            lap_hit <= 1'b0;
            drive   <= 1'b0;
            k       <= '0;
            if (operation == OP_CAL) begin
              for (int i = 0; i < CH_N; i++) begin
                if (samples[i] > chan_max[i]) chan_max[i] <= samples[i];
                if (samples[i] < chan_min[i]) chan_min[i] <= samples[i];
              end
              state <= S_WR;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (nm_span == '0) begin
            n[k]  <= '0;
            fault <= 1'b1;
            if (last_ch) begin
              state <= S_CHECK;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            q_neg <= nm_num[NORM_W-1] ^ nm_span[SAMPLE_W];
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (div_done) begin
            n[k] <= q_signed[NORM_W-1:0];
            if (last_ch) begin
              state <= S_CHECK;
            end else begin
              k     <= k + 1'b1;
              state <= S_NORM;
            end
          end
        end
        S_CHECK: begin
          if (stop) begin
            state <= S_WR;
          end else begin
            if (lap_arm) begin
              armed     <= 1'b1;
              lap_count <= lap_count + 1'b1;
              lap_hit   <= 1'b1;
            end else if (lap_disarm) begin
              armed <= 1'b0;
            end
            if (fork_hit) begin
              if (cfg.turn_pref) n[1] <= NORM_FULL;
              else n[3] <= NORM_FULL;
            end
            state <= S_CENT;
          end
        end
        S_CENT: begin
          if (c_den == '0) begin
            pos   <= '0;
            fault <= 1'b1;
            state <= S_ERR;
          end else begin
            q_neg <= c_num[CNUM_W-1] ^ c_den[CDEN_W-1];
            state <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (div_done) begin
            pos   <= q_signed[POS_W-1:0];
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err            <= err_v;
          der            <= der_v;
          integ          <= integ_sat;
          error_integral <= integ_sat;
          prev_error     <= err_v;
          state          <= S_MULP;
        end
        S_MULP: begin
          prod  <= mul_p;
          state <= S_MULD;
        end
        S_MULD: begin
          acc   <= ACC_W'(prod);
          prod  <= mul_p;
          state <= S_MULI;
        end
        S_MULI: begin
          acc   <= acc + ACC_W'(prod);
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + ACC_W'(prod);
          drive <= 1'b1;
          state <= S_DUTY;
        end
        S_DUTY: begin
          da    <= clamp_duty(sum_a);
          db    <= clamp_duty(sum_b);
          state <= S_WR;
        end
        S_WR: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.motors_on     = drive;
    res.duty_a        = drive ? duty_to_pwm(da) : '0;
    res.duty_b        = drive ? duty_to_pwm(db) : '0;
    res.line_position = drive ? pos : '0;
    res.lap_total     = lap_count;
    res.lap_event     = lap_hit;
    res.divide_fault  = fault;
  end

  assign idle     = (state == S_IDLE);
  assign res_load = (state == S_WR) && out_free;

endmodule

`default_nettype wire

/* sv/line_follow_pd_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// Line follower steering: calibration, normalization, lap count, PID duties.
//
//   channel   words              handshake
//   cfg       index, data        cfg_valid / cfg_ready (always ready)
//   in        operation, 5 ch    in_valid / in_ready
//   out       duties, status     out_valid / out_ready
//
// a calibrate word goes straight to its result; a run word makes up to six
// passes through the shared divider (five normalizations, one centroid),
// each zero divisor skipping its pass
// in_ready is high only while the sequencer is idle
// a result waits in the output register while the next word is taken
// reset is synchronous and restores calibration, lap and PID state
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pd_steering
  import lfpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [SAMPLE_W-1:0]     sample_ch0,
  input  logic [SAMPLE_W-1:0]     sample_ch1,
  input  logic [SAMPLE_W-1:0]     sample_ch2,
  input  logic [SAMPLE_W-1:0]     sample_ch3,
  input  logic [SAMPLE_W-1:0]     sample_ch4,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    motors_on,
  output logic [PWM_W-1:0]        duty_a,
  output logic [PWM_W-1:0]        duty_b,
  output logic signed [POS_W-1:0] line_position,
  output logic [LAP_W-1:0]        lap_total,
  output logic                    lap_event,
  output logic                    divide_fault
);

  cfg_t     cfg;
  samples_t samples;
  res_t     res;
  res_t     res_q;
  logic     idle;
  logic     res_load;
  logic     out_free;

  assign cfg_ready = 1'b1;
  assign samples   = {sample_ch4, sample_ch3, sample_ch2, sample_ch1, sample_ch0};
  assign in_ready  = idle;
  assign out_free  = !out_valid || out_ready;

  lfpd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lfpd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .operation (operation),
    .samples   (samples),
    .cfg       (cfg),
    .out_free  (out_free),
    .idle      (idle),
    .res_load  (res_load),
    .res       (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_q <= res;
  end

  assign motors_on     = res_q.motors_on;
  assign duty_a        = res_q.duty_a;
  assign duty_b        = res_q.duty_b;
  assign line_position = res_q.line_position;
  assign lap_total     = res_q.lap_total;
  assign lap_event     = res_q.lap_event;
  assign divide_fault  = res_q.divide_fault;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the word finished");
  a_stopped_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motors_on |-> duty_a == '0 && duty_b == '0 && !lap_event &&
    line_position == '0)
    else $error("stopped word carries drive fields");

endmodule

`default_nettype wire
